// ----- hw/rtl/point_rotation_about_pivot_top_defines.svh -----
`ifndef POINT_ROTATION_ABOUT_PIVOT_TOP_DEFINES_SVH
`define POINT_ROTATION_ABOUT_PIVOT_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PRAP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must hold on every clock edge outside reset
`define PRAP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hw/rtl/prap_pkg.sv -----
`default_nettype none

package prap_pkg;

	localparam int COORD_WIDTH   = 20;
	localparam int ANGLE_WIDTH   = 17;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_SIZE    = 24;
	localparam int NS = (CORDIC_STAGES < TABLE_SIZE) ? CORDIC_STAGES : TABLE_SIZE;
	localparam int IDX_W = $clog2(TABLE_SIZE);

	localparam int DIFF_W = COORD_WIDTH + 1;

	// angle reduction and binary angle conversion
	localparam int FULL_TURN = 23040;
	localparam int MOD_FOLDS = 5;
	localparam int MOD_BIAS  = 3 * FULL_TURN;
	localparam int V_W       = 18;
	localparam int R_W       = 15;
	localparam int RECIP       = 46604;
	localparam int RECIP_SHIFT = 21;
	localparam int PRODA_W     = 31;
	localparam int DIV45       = 45;
	localparam int A_W         = 9;
	localparam int B_W         = 6;
	localparam int FRAC_MUL    = 186413;
	localparam int FRAC_W      = 23;
	localparam int BIN_W       = A_W + FRAC_W;

	// CORDIC datapath
	localparam int CW = 34;
	localparam int ZW = 34;
	localparam logic signed [CW-1:0] GAIN = CW'(652032874);

	// output arithmetic
	localparam int RND_SHIFT = 6;
	localparam int CS_W      = CW - RND_SHIFT;
	localparam logic signed [CW-1:0] CS_HALF = CW'(1 << (RND_SHIFT - 1));
	localparam int Q_SHIFT   = 24;
	localparam int PROD_W    = DIFF_W + CS_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int RND_W     = SUM_W - Q_SHIFT;
	localparam int FULL_W    = RND_W + 1;
	localparam logic signed [SUM_W-1:0] Q_HALF = SUM_W'(1 << (Q_SHIFT - 1));

	localparam int FRONT_STAGES = 4;
	localparam int MIX_STAGES   = 4;
	localparam int LATENCY      = FRONT_STAGES + NS + MIX_STAGES;

	typedef struct packed {
		logic                     flip;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [COORD_WIDTH-1:0] px;
		logic signed [COORD_WIDTH-1:0] py;
	} side_t;

	// atan(2^-i) in binary angle units, full turn = 2^32
	function automatic logic signed [ZW-1:0] arc_step(input logic [IDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0:    v = ZW'(536870912);
			5'd1:    v = ZW'(316933405);
			5'd2:    v = ZW'(167458907);
			5'd3:    v = ZW'(85004756);
			5'd4:    v = ZW'(42667331);
			5'd5:    v = ZW'(21354465);
			5'd6:    v = ZW'(10681886);
			5'd7:    v = ZW'(5340245);
			5'd8:    v = ZW'(2670163);
			5'd9:    v = ZW'(1335086);
			5'd10:   v = ZW'(667544);
			5'd11:   v = ZW'(333772);
			5'd12:   v = ZW'(166886);
			5'd13:   v = ZW'(83443);
			5'd14:   v = ZW'(41721);
			5'd15:   v = ZW'(20860);
			5'd16:   v = ZW'(10430);
			5'd17:   v = ZW'(5215);
			5'd18:   v = ZW'(2607);
			5'd19:   v = ZW'(1303);
			5'd20:   v = ZW'(651);
			5'd21:   v = ZW'(325);
			5'd22:   v = ZW'(162);
			5'd23:   v = ZW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prap_front.sv -----
`default_nettype none
`include "point_rotation_about_pivot_top_defines.svh"

module prap_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] pivot_x,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] pivot_y,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [prap_pkg::ANGLE_WIDTH-1:0] turn_degrees,
	output logic                                        out_valid,
	output prap_pkg::side_t                             out_side,
	output logic signed [prap_pkg::ZW-1:0]              out_z
);

	logic [prap_pkg::V_W-1:0]     v_w;
	logic [prap_pkg::V_W-1:0]     rem_w;
	logic [prap_pkg::A_W-1:0]     a_w;
	logic [prap_pkg::R_W-1:0]     a_mul45_w;
	logic [prap_pkg::FRAC_W-1:0]  frac_w;
	logic [prap_pkg::BIN_W-1:0]   bin_w;
	logic                         flip_w;

	logic                         valid_s1, valid_s2, valid_s3, valid_s4;
	prap_pkg::side_t              side_s1, side_s2, side_s3, side_s4;
	logic [prap_pkg::R_W-1:0]     r_s1, r_s2;
	logic [prap_pkg::PRODA_W-1:0] prod_s2;
	logic [prap_pkg::A_W-1:0]     a_s3;
	logic [prap_pkg::B_W-1:0]     b_s3;
	logic signed [prap_pkg::ZW-1:0] z_s4;

	// angle modulo one turn
	always_comb begin
		v_w = prap_pkg::V_W'(int'(turn_degrees) + prap_pkg::MOD_BIAS);
		rem_w = v_w;
		for (int k = 1; k <= prap_pkg::MOD_FOLDS; k++) begin
			if (v_w >= prap_pkg::V_W'(k * prap_pkg::FULL_TURN)) begin
				rem_w = v_w - prap_pkg::V_W'(k * prap_pkg::FULL_TURN);
			end
		end
	end

	// r = 45*a + b, bin = a*2^23 + floor((b*2^23 + 22) / 45)
	assign a_w       = prod_s2[prap_pkg::RECIP_SHIFT +: prap_pkg::A_W];
	assign a_mul45_w = prap_pkg::R_W'(32'(a_w) * 32'(prap_pkg::DIV45));
	assign frac_w    = prap_pkg::FRAC_W'(32'(b_s3) * 32'(prap_pkg::FRAC_MUL)
		+ ((32'(b_s3) + 32'd1) >> 1));
	assign bin_w     = {a_s3, frac_w};
	assign flip_w    = bin_w[prap_pkg::BIN_W-1] ^ bin_w[prap_pkg::BIN_W-2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.flip <= 1'b0;
		side_s1.dx   <= prap_pkg::DIFF_W'(point_x) - prap_pkg::DIFF_W'(pivot_x);
		side_s1.dy   <= prap_pkg::DIFF_W'(point_y) - prap_pkg::DIFF_W'(pivot_y);
		side_s1.px   <= pivot_x;
		side_s1.py   <= pivot_y;
		r_s1         <= prap_pkg::R_W'(rem_w);

		side_s2 <= side_s1;
		r_s2    <= r_s1;
		prod_s2 <= prap_pkg::PRODA_W'(32'(r_s1) * 32'(prap_pkg::RECIP));

		side_s3 <= side_s2;
		a_s3    <= a_w;
		b_s3    <= prap_pkg::B_W'(r_s2 - a_mul45_w);

		side_s4 <= {flip_w, side_s3.dx, side_s3.dy, side_s3.px, side_s3.py};
		z_s4 <= prap_pkg::ZW'($signed({bin_w[prap_pkg::BIN_W-1] ^ flip_w,
			bin_w[prap_pkg::BIN_W-2:0]}));
	end

	assign out_valid = valid_s4;
	assign out_side  = side_s4;
	assign out_z     = z_s4;

	`PRAP_ASSERT_IMPLY(a_rem_range, valid_s3, 32'(b_s3) < 32'(prap_pkg::DIV45), "remainder not below 45")
	`PRAP_ASSERT_IMPLY(a_quadrant, valid_s4, (z_s4[prap_pkg::ZW-1:30] == '0) || (z_s4[prap_pkg::ZW-1:30] == '1), "angle outside first or fourth quadrant")

endmodule

`default_nettype wire

// ----- hw/rtl/prap_cell.sv -----
`default_nettype none

module prap_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [prap_pkg::IDX_W-1:0]    stage,
	input  wire logic                          in_valid,
	input  wire prap_pkg::side_t               in_side,
	input  wire logic signed [prap_pkg::CW-1:0] in_x,
	input  wire logic signed [prap_pkg::CW-1:0] in_y,
	input  wire logic signed [prap_pkg::ZW-1:0] in_z,
	output logic                               out_valid,
	output prap_pkg::side_t                    out_side,
	output logic signed [prap_pkg::CW-1:0]     out_x,
	output logic signed [prap_pkg::CW-1:0]     out_y,
	output logic signed [prap_pkg::ZW-1:0]     out_z
);

	logic signed [prap_pkg::CW-1:0] xs_w, ys_w;
	logic signed [prap_pkg::ZW-1:0] arc_w;
	logic                           pos_w;

	logic                           valid_q;
	prap_pkg::side_t                side_q;
	logic signed [prap_pkg::CW-1:0] x_q, y_q;
	logic signed [prap_pkg::ZW-1:0] z_q;

	assign xs_w  = in_x >>> stage;
	assign ys_w  = in_y >>> stage;
	assign arc_w = prap_pkg::arc_step(stage);
	assign pos_w = !in_z[prap_pkg::ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= in_side;
		if (pos_w) begin
			x_q <= in_x - ys_w;
			y_q <= in_y + xs_w;
			z_q <= in_z - arc_w;
		end else begin
			x_q <= in_x + ys_w;
			y_q <= in_y - xs_w;
			z_q <= in_z + arc_w;
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;

endmodule

`default_nettype wire

// ----- hw/rtl/prap_mix.sv -----
`default_nettype none
`include "point_rotation_about_pivot_top_defines.svh"

module prap_mix (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire prap_pkg::side_t                in_side,
	input  wire logic signed [prap_pkg::CW-1:0] in_x,
	input  wire logic signed [prap_pkg::CW-1:0] in_y,
	output logic                                done,
	output logic signed [prap_pkg::COORD_WIDTH-1:0] rotated_x,
	output logic signed [prap_pkg::COORD_WIDTH-1:0] rotated_y
);

	localparam int CWD = prap_pkg::COORD_WIDTH;
	localparam logic signed [prap_pkg::CS_W-1:0] CS_LIM =
		prap_pkg::CS_W'((1 << 24) + (1 << 10));
	localparam logic signed [CWD-1:0] SAT_HI = {1'b0, {(CWD-1){1'b1}}};
	localparam logic signed [CWD-1:0] SAT_LO = {1'b1, {(CWD-1){1'b0}}};

	logic signed [prap_pkg::CW-1:0]     xf_w, yf_w, xr_w, yr_w;
	logic signed [prap_pkg::SUM_W-1:0]  sum_x_w, sum_y_w;
	logic signed [prap_pkg::FULL_W-1:0] full_x_w, full_y_w;
	logic signed [CWD-1:0]              sat_x_w, sat_y_w;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	prap_pkg::side_t     side_s1, side_s2, side_s3;
	logic signed [prap_pkg::CS_W-1:0]   c_s1, s_s1;
	logic signed [prap_pkg::PROD_W-1:0] p_xc_s2, p_ys_s2, p_xs_s2, p_yc_s2;
	logic signed [prap_pkg::RND_W-1:0]  rx_s3, ry_s3;
	logic signed [CWD-1:0]              rot_x_s4, rot_y_s4;

	assign xf_w = in_side.flip ? -in_x : in_x;
	assign yf_w = in_side.flip ? -in_y : in_y;
	assign xr_w = xf_w + prap_pkg::CS_HALF;
	assign yr_w = yf_w + prap_pkg::CS_HALF;

	assign sum_x_w = prap_pkg::SUM_W'(p_xc_s2) - prap_pkg::SUM_W'(p_ys_s2) + prap_pkg::Q_HALF;
	assign sum_y_w = prap_pkg::SUM_W'(p_xs_s2) + prap_pkg::SUM_W'(p_yc_s2) + prap_pkg::Q_HALF;

	assign full_x_w = prap_pkg::FULL_W'(side_s3.px) + prap_pkg::FULL_W'(rx_s3);
	assign full_y_w = prap_pkg::FULL_W'(side_s3.py) + prap_pkg::FULL_W'(ry_s3);

	always_comb begin
		sat_x_w = full_x_w[CWD-1:0];
		if ((full_x_w[prap_pkg::FULL_W-1:CWD-1] != '0) &&
		    (full_x_w[prap_pkg::FULL_W-1:CWD-1] != '1)) begin
			sat_x_w = full_x_w[prap_pkg::FULL_W-1] ? SAT_LO : SAT_HI;
		end
		sat_y_w = full_y_w[CWD-1:0];
		if ((full_y_w[prap_pkg::FULL_W-1:CWD-1] != '0) &&
		    (full_y_w[prap_pkg::FULL_W-1:CWD-1] != '1)) begin
			sat_y_w = full_y_w[prap_pkg::FULL_W-1] ? SAT_LO : SAT_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= in_side;
		c_s1    <= xr_w[prap_pkg::CW-1:prap_pkg::RND_SHIFT];
		s_s1    <= yr_w[prap_pkg::CW-1:prap_pkg::RND_SHIFT];

		side_s2 <= side_s1;
		p_xc_s2 <= prap_pkg::PROD_W'(side_s1.dx) * prap_pkg::PROD_W'(c_s1);
		p_ys_s2 <= prap_pkg::PROD_W'(side_s1.dy) * prap_pkg::PROD_W'(s_s1);
		p_xs_s2 <= prap_pkg::PROD_W'(side_s1.dx) * prap_pkg::PROD_W'(s_s1);
		p_yc_s2 <= prap_pkg::PROD_W'(side_s1.dy) * prap_pkg::PROD_W'(c_s1);

		side_s3 <= side_s2;
		rx_s3   <= sum_x_w[prap_pkg::SUM_W-1:prap_pkg::Q_SHIFT];
		ry_s3   <= sum_y_w[prap_pkg::SUM_W-1:prap_pkg::Q_SHIFT];

		rot_x_s4 <= sat_x_w;
		rot_y_s4 <= sat_y_w;
	end

	assign done      = valid_s4;
	assign rotated_x = rot_x_s4;
	assign rotated_y = rot_y_s4;

	`PRAP_ASSERT_ALWAYS(a_cs_bound, !valid_s1 || ((c_s1 <= CS_LIM) && (c_s1 >= -CS_LIM) && (s_s1 <= CS_LIM) && (s_s1 >= -CS_LIM)), "sine or cosine out of unit range")

endmodule

`default_nettype wire

// ----- hw/rtl/point_rotation_about_pivot_top.sv -----
// Pipeline from the start transfer to the done strobe: 4 angle stages,
// one per CORDIC cell, 4 output stages.
// Throughput: one transfer per cycle; busy is never raised, the pipeline has no stall.
// The receiver cannot stall: each result is shown for one cycle with done.
// arst_n clears all pipeline valid bits; no result follows reset until new starts.
`default_nettype none
`include "point_rotation_about_pivot_top_defines.svh"

module point_rotation_about_pivot_top (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	output logic                                         busy,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] pivot_x,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] pivot_y,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] point_x,
	input  wire logic signed [prap_pkg::COORD_WIDTH-1:0] point_y,
	input  wire logic signed [prap_pkg::ANGLE_WIDTH-1:0] turn_degrees,
	output logic                                         done,
	output logic signed [prap_pkg::COORD_WIDTH-1:0]      rotated_x,
	output logic signed [prap_pkg::COORD_WIDTH-1:0]      rotated_y
);

	logic                           cv [0:prap_pkg::NS];
	prap_pkg::side_t                cs [0:prap_pkg::NS];
	logic signed [prap_pkg::CW-1:0] cx [0:prap_pkg::NS];
	logic signed [prap_pkg::CW-1:0] cy [0:prap_pkg::NS];
	logic signed [prap_pkg::ZW-1:0] cz [0:prap_pkg::NS];

	assign busy = 1'b0;

	prap_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start),
		.pivot_x      (pivot_x),
		.pivot_y      (pivot_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.turn_degrees (turn_degrees),
		.out_valid    (cv[0]),
		.out_side     (cs[0]),
		.out_z        (cz[0])
	);

	assign cx[0] = prap_pkg::GAIN;
	assign cy[0] = '0;

	for (genvar k = 0; k < prap_pkg::NS; k++) begin : g_cell
		prap_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage     (prap_pkg::IDX_W'(k)),
			.in_valid  (cv[k]),
			.in_side   (cs[k]),
			.in_x      (cx[k]),
			.in_y      (cy[k]),
			.in_z      (cz[k]),
			.out_valid (cv[k+1]),
			.out_side  (cs[k+1]),
			.out_x     (cx[k+1]),
			.out_y     (cy[k+1]),
			.out_z     (cz[k+1])
		);
	end

	prap_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv[prap_pkg::NS]),
		.in_side   (cs[prap_pkg::NS]),
		.in_x      (cx[prap_pkg::NS]),
		.in_y      (cy[prap_pkg::NS]),
		.done      (done),
		.rotated_x (rotated_x),
		.rotated_y (rotated_y)
	);

	`PRAP_ASSERT_IMPLY(a_done_follows_start, done, $past(start, prap_pkg::LATENCY), "done without a start transfer")

endmodule

`default_nettype wire

// ----- tb/point_rotation_about_pivot_top_test.sv -----
`timescale 1ns / 1ps

module point_rotation_about_pivot_top_test;

	localparam int CW = prap_pkg::COORD_WIDTH;
	localparam int AW = prap_pkg::ANGLE_WIDTH;
	localparam int P_MAX = (1 << (CW - 1)) - 1;
	localparam int P_MIN = -(1 << (CW - 1));
	localparam int A_MAX = (1 << (AW - 1)) - 1;
	localparam int A_MIN = -(1 << (AW - 1));
	localparam int DEG45 = 2880;
	localparam int DEG90 = 5760;
	localparam int DEG180 = 11520;
	localparam int DEG360 = 23040;
	localparam int ARC_COUNT = 24;
	localparam longint GAIN_Q30 = 652032874;
	localparam int RANDOM_ITEMS = 1950;
	localparam int MAX_REPORTS = 10;

	localparam longint ARC_TABLE [ARC_COUNT] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10681886, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81
	};

	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		logic signed [AW-1:0] ang;
	} rot_item_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} rot_point_t;

	typedef struct packed {
		rot_item_t  item;
		logic       typed;
		rot_point_t want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [CW-1:0] pivot_x = '0;
	logic signed [CW-1:0] pivot_y = '0;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic signed [AW-1:0] turn_degrees = '0;
	logic busy;
	logic done;
	logic signed [CW-1:0] rotated_x;
	logic signed [CW-1:0] rotated_y;

	rot_point_t expected_points [$];
	dir_row_t   dir_rows [$];
	rot_point_t mon_want;
	int         err_count = 0;
	bit         no_idle = 1'b0;

	point_rotation_about_pivot_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pivot_x      (pivot_x),
		.pivot_y      (pivot_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.turn_degrees (turn_degrees),
		.done         (done),
		.rotated_x    (rotated_x),
		.rotated_y    (rotated_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// angle in Q10.6 degrees -> cos, sin in Q24
	function automatic void cordic_cos_sin(input longint deg, output longint c,
			output longint s);
		longint r, bin, quad, x, y, z, xs, ys;
		bit flip;
		int stages;
		r = deg % DEG360;
		if (r < 0)
			r += DEG360;
		bin = ((r << 32) + DEG180) / DEG360;
		quad = (bin >> 30) & 3;
		flip = 1'b0;
		if (quad == 1 || quad == 2) begin
			bin = (bin + (64'sd1 << 31)) & 64'shFFFFFFFF;
			flip = 1'b1;
		end
		z = (bin >= (64'sd1 << 31)) ? bin - (64'sd1 << 32) : bin;
		x = GAIN_Q30;
		y = 0;
		stages = (prap_pkg::CORDIC_STAGES < ARC_COUNT) ? prap_pkg::CORDIC_STAGES : ARC_COUNT;
		for (int i = 0; i < stages; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ARC_TABLE[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ARC_TABLE[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + 32) >>> 6;
		s = (y + 32) >>> 6;
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(input longint v);
		if (v > P_MAX)
			return CW'(P_MAX);
		if (v < P_MIN)
			return CW'(P_MIN);
		return CW'(v);
	endfunction

	function automatic rot_point_t rotate_about_pivot(input rot_item_t it);
		longint px, py, dx, dy, c, s;
		rot_point_t res;
		px = longint'(it.px);
		py = longint'(it.py);
		dx = longint'(it.qx) - px;
		dy = longint'(it.qy) - py;
		cordic_cos_sin(longint'(it.ang), c, s);
		res.x = clamp_coord(px + ((dx * c - dy * s + (64'sd1 << 23)) >>> 24));
		res.y = clamp_coord(py + ((dx * s + dy * c + (64'sd1 << 23)) >>> 24));
		return res;
	endfunction

	task automatic add_row(input int px, input int py, input int qx, input int qy,
			input int ang, input bit typed, input int ex, input int ey);
		dir_row_t row;
		row.item.px = CW'(px);
		row.item.py = CW'(py);
		row.item.qx = CW'(qx);
		row.item.qy = CW'(qy);
		row.item.ang = AW'(ang);
		row.typed = typed;
		row.want.x = CW'(ex);
		row.want.y = CW'(ey);
		dir_rows.push_back(row);
	endtask

	function automatic int small_coord();
		return int'($urandom_range(0, 32767)) - 16384;
	endfunction

	function automatic rot_item_t random_item();
		rot_item_t it;
		int kind, k;
		kind = $urandom_range(0, 9);
		it.px = CW'($urandom());
		it.py = CW'($urandom());
		it.qx = CW'($urandom());
		it.qy = CW'($urandom());
		it.ang = AW'($urandom());
		if (kind <= 4 || kind >= 8) begin
			it.px = CW'(small_coord() * 16);
			it.py = CW'(small_coord() * 16);
			it.qx = CW'(int'(it.px) + small_coord());
			it.qy = CW'(int'(it.py) + small_coord());
		end else if (kind == 7) begin
			it.px = ($urandom_range(0, 1) == 1) ? CW'(P_MAX - int'($urandom_range(0, 255)))
				: CW'(P_MIN + int'($urandom_range(0, 255)));
			it.py = ($urandom_range(0, 1) == 1) ? CW'(P_MAX - int'($urandom_range(0, 255)))
				: CW'(P_MIN + int'($urandom_range(0, 255)));
		end
		if (kind >= 8) begin
			// near quadrant boundaries
			k = int'($urandom_range(0, 22)) - 11;
			it.ang = AW'(k * DEG90 + int'($urandom_range(0, 4)) - 2);
		end
		return it;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : int'($urandom_range(0, 6));
	endfunction

	task automatic flag_error(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, what);
	endtask

	task automatic send_item(input rot_item_t it, input rot_point_t want, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pivot_x <= it.px;
		pivot_y <= it.py;
		point_x <= it.qx;
		point_y <= it.qy;
		turn_degrees <= it.ang;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		expected_points.push_back(want);
	endtask

	always @(negedge clk) begin
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				flag_error($sformatf("result with no transfer pending: x=%0d y=%0d",
					rotated_x, rotated_y));
			end else begin
				mon_want = expected_points.pop_front();
				if (rotated_x !== mon_want.x || rotated_y !== mon_want.y)
					flag_error($sformatf("expected x=%0d y=%0d, got x=%0d y=%0d",
						mon_want.x, mon_want.y, rotated_x, rotated_y));
			end
		end
	end

	initial begin
		rot_item_t it;
		rot_point_t want;

		add_row(0, 0, 0, 0, 0, 1'b1, 0, 0);
		add_row(P_MAX, P_MIN, P_MAX, P_MIN, A_MAX, 1'b1, P_MAX, P_MIN);
		add_row(P_MIN, P_MAX, P_MIN, P_MAX, A_MIN, 1'b1, P_MIN, P_MAX);
		add_row(P_MAX, P_MAX, P_MIN, P_MIN, DEG180, 1'b1, P_MAX, P_MAX);
		add_row(P_MIN, P_MIN, P_MAX, P_MAX, DEG180, 1'b1, P_MIN, P_MIN);
		add_row(0, 0, 256, 0, 0, 1'b0, 0, 0);
		add_row(0, 0, 256, 0, DEG90, 1'b0, 0, 0);
		add_row(0, 0, 256, 0, -DEG90, 1'b0, 0, 0);
		add_row(0, 0, 256, 0, DEG180, 1'b0, 0, 0);
		add_row(0, 0, 256, 0, 3 * DEG90, 1'b0, 0, 0);
		add_row(0, 0, 256, 0, DEG360, 1'b0, 0, 0);
		add_row(0, 0, 256, 0, -DEG360, 1'b0, 0, 0);
		add_row(0, 0, 256, 256, DEG45, 1'b0, 0, 0);
		add_row(1000, -2000, 3000, 500, DEG90 - 1, 1'b0, 0, 0);
		add_row(1000, -2000, 3000, 500, DEG90 + 1, 1'b0, 0, 0);
		add_row(1000, -2000, 3000, 500, A_MAX, 1'b0, 0, 0);
		add_row(1000, -2000, 3000, 500, A_MIN, 1'b0, 0, 0);
		add_row(-1, -1, 1, 1, DEG360 - 1, 1'b0, 0, 0);
		add_row(0, 0, P_MAX, P_MAX, DEG45, 1'b0, 0, 0);
		add_row(0, 0, P_MIN, 0, DEG90, 1'b0, 0, 0);
		add_row(P_MAX, 0, P_MIN, 0, DEG90, 1'b0, 0, 0);
		add_row(P_MIN, P_MIN, P_MAX, P_MAX, 0, 1'b0, 0, 0);
		add_row(0, P_MAX, 0, P_MIN, -DEG45, 1'b0, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			want = dir_rows[i].typed ? dir_rows[i].want : rotate_about_pivot(dir_rows[i].item);
			send_item(dir_rows[i].item, want, draw_gap());
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			it = random_item();
			send_item(it, rotate_about_pivot(it), draw_gap());
		end
		start <= 1'b0;

		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (prap_pkg::LATENCY + 8) @(posedge clk);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/prap_pkg.sv
hw/rtl/prap_front.sv
hw/rtl/prap_cell.sv
hw/rtl/prap_mix.sv
hw/rtl/point_rotation_about_pivot_top.sv
tb/point_rotation_about_pivot_top_test.sv
